/* src/twsm_pkg.sv */
// ----------------------------------------------------------------------------
// twsm_pkg - shared types and constants of the three-wire serial master
// phase codes of the pin sequencer and the packed layout of one result
// ----------------------------------------------------------------------------
package twsm_pkg;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned RES_W      = 14;

	// sequencer phase codes
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_CE_LOW  = 4'd1;
	localparam logic [3:0] PH_CLK_LOW = 4'd2;
	localparam logic [3:0] PH_CE_HIGH = 4'd3;
	localparam logic [3:0] PH_SETUP   = 4'd4;
	localparam logic [3:0] PH_CLK_HI  = 4'd5;
	localparam logic [3:0] PH_CLK_LO  = 4'd6;
	localparam logic [3:0] PH_END_CLK = 4'd7;
	localparam logic [3:0] PH_END_CE  = 4'd8;

	localparam logic [3:0] LAST_BIT   = 4'd15;
	localparam logic [7:0] HALF_RESET = 8'd4;

	// configuration register byte addresses
	localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;

	// one result, last field in the lowest bits
	typedef struct packed {
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       io_drive;
		logic       io_out;
		logic       serial_clock;
		logic       chip_enable;
	} res_t;

endpackage

/* src/three_wire_serial_master.sv */
// ----------------------------------------------------------------------------
// three_wire_serial_master - chip enable / clock / data line sequencer
// each input transfer is one tick; each result transfer gives the pin levels
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one transfer per tick. s_tdata holds start_req, command,
//   write_data and the sampled data line io_in; s_tuser holds req_type.
//   A start_req while idle latches the request and begins the sequence:
//   enable low and clock low, enable high, 16 bit slots (command, then
//   write data or eight sampled read bits), clock high, enable low.
//   m_* channel: one result per input tick, with the line levels, busy,
//   a one-tick done pulse and the last read byte.
//   Each pin phase is held for half_period ticks (APB register at 0x0).
// Pipeline and throughput
//   a result passes the input register, then the result register; one
//   item per cycle is sustained while m_tready stays high.
// Reset
//   the sequencer goes idle with clock high, enable low, line released;
//   half_period returns to 4.
// Stalls
//   while m_tready is low the result holds, the input register fills and
//   s_tready drops; no tick is dropped or repeated.
// ----------------------------------------------------------------------------
module three_wire_serial_master (
	input  logic                             clk,
	input  logic                             arst_n,
	// apb configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// tick input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [twsm_pkg::IN_DATA_W-1:0]   s_tdata,  // start_req, command, write_data, io_in
	input  logic                             s_tuser,  // req_type
	// result output
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [twsm_pkg::OUT_DATA_W-1:0]  m_tdata   // chip_enable, serial_clock, io_out,
	                                                   // io_drive, busy_res, done_res, read_data
);
	import twsm_pkg::*;

	logic [7:0]  half_q;

	logic        in_valid_s1;
	logic        start_s1;
	logic        typ_s1;
	logic [7:0]  cmd_s1;
	logic [7:0]  wd_s1;
	logic        io_s1;

	logic [3:0]  phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [15:0] tx_q, tx_d;
	logic [7:0]  rx_q, rx_d;
	logic [7:0]  hold_q, hold_d;
	logic        is_read_q, is_read_d;

	logic        out_valid_q;
	res_t        res_q, res_d;
	logic        proc;
	logic [7:0]  hold_inc;
	logic        bit_slot;
	logic        cfg_wr;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == ADDR_HALF_PERIOD[2]) ? {24'd0, half_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_wr && paddr[2] == ADDR_HALF_PERIOD[2]) begin
			half_q <= pwdata[7:0];
		end
	end

	// handshake
	assign proc     = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || proc;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
			cmd_s1   <= s_tdata[8:1];
			wd_s1    <= s_tdata[16:9];
			io_s1    <= s_tdata[17];
			typ_s1   <= s_tuser;
		end
	end

	// next state of the sequencer for one tick
	assign hold_inc = hold_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		bit_d     = bit_q;
		tx_d      = tx_q;
		rx_d      = rx_q;
		hold_d    = hold_q;
		is_read_d = is_read_q;
		if (phase_q == PH_IDLE) begin
			if (start_s1) begin
				is_read_d = ~typ_s1;
				tx_d      = {(typ_s1 ? wd_s1 : 8'h00), cmd_s1};
				if (!typ_s1) begin
					rx_d = 8'h00;
				end
				bit_d   = 4'd0;
				hold_d  = 8'd0;
				phase_d = PH_CE_LOW;
			end
		end else begin
			hold_d = hold_inc;
			if (hold_inc >= half_q) begin
				hold_d = 8'd0;
				case (phase_q)
					PH_CE_LOW:  phase_d = PH_CLK_LOW;
					PH_CLK_LOW: phase_d = PH_CE_HIGH;
					PH_CE_HIGH: phase_d = PH_SETUP;
					PH_SETUP: begin
						// read slots sample the line and shift in from the top
						if (is_read_q && bit_q[3]) begin
							rx_d = {io_s1, rx_q[7:1]};
						end
						phase_d = PH_CLK_HI;
					end
					PH_CLK_HI:  phase_d = PH_CLK_LO;
					PH_CLK_LO: begin
						tx_d = {1'b0, tx_q[15:1]};
						if (bit_q == LAST_BIT) begin
							phase_d = PH_END_CLK;
						end else begin
							bit_d   = bit_q + 4'd1;
							phase_d = PH_SETUP;
						end
					end
					PH_END_CLK: phase_d = PH_END_CE;
					PH_END_CE:  phase_d = PH_IDLE;
					default:    phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// line levels after this tick
	always_comb begin
		res_d          = '0;
		bit_slot       = 1'b0;
		res_d.busy_res = (phase_d != PH_IDLE);
		res_d.done_res = (phase_q == PH_END_CE) && (phase_d == PH_IDLE);
		res_d.read_data = rx_d;
		case (phase_d)
			PH_CE_LOW:  res_d.serial_clock = 1'b1;
			PH_CLK_LOW: res_d.serial_clock = 1'b0;
			PH_CE_HIGH: res_d.chip_enable  = 1'b1;
			PH_SETUP: begin
				res_d.chip_enable = 1'b1;
				bit_slot          = 1'b1;
			end
			PH_CLK_HI: begin
				res_d.chip_enable  = 1'b1;
				res_d.serial_clock = 1'b1;
				bit_slot           = 1'b1;
			end
			PH_CLK_LO: begin
				res_d.chip_enable = 1'b1;
				bit_slot          = 1'b1;
			end
			PH_END_CLK: begin
				res_d.chip_enable  = 1'b1;
				res_d.serial_clock = 1'b1;
			end
			PH_END_CE:  res_d.serial_clock = 1'b1;
			default:    res_d.serial_clock = 1'b1;
		endcase
		if (bit_slot && !(is_read_d && bit_d[3])) begin
			res_d.io_drive = 1'b1;
			res_d.io_out   = tx_d[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 4'd0;
			tx_q        <= 16'd0;
			rx_q        <= 8'd0;
			hold_q      <= 8'd0;
			is_read_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (proc) begin
				phase_q   <= phase_d;
				bit_q     <= bit_d;
				tx_q      <= tx_d;
				rx_q      <= rx_d;
				hold_q    <= hold_d;
				is_read_q <= is_read_d;
			end
			if (proc) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res_d;
		end
	end

	// done only on the tick that returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done pulse while still busy");

	// the data line carries a level only while driven
	a_io_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.io_out |-> res_q.io_drive)
		else $error("io_out high while line released");

	// idle lines: enable low, clock high, released
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.busy_res |->
			!res_q.chip_enable && res_q.serial_clock && !res_q.io_drive)
		else $error("idle line levels wrong");

	// sequencer state moves only on a processed tick
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!proc |=> $stable(phase_q) && $stable(rx_q) && $stable(hold_q))
		else $error("sequencer state changed without a tick");

endmodule

/* sim/three_wire_serial_master_tb.sv */
// ----------------------------------------------------------------------------
// three_wire_serial_master_tb - self-checking bench of the three-wire master
// drives one tick per input transfer, predicts the pin levels, busy, done and
// read byte of every tick, and compares each result transfer in order; runs
// through several half_period settings with random idling on both streams
// ----------------------------------------------------------------------------
module three_wire_serial_master_tb;
	import twsm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_OFF    = 400;
	localparam int unsigned DRAIN_WAIT  = 8;

	typedef struct {
		logic       start_req;
		logic       req_type;
		logic [7:0] command;
		logic [7:0] write_data;
		logic       io_in;
	} tick_t;

	// follows the sequencer tick by tick and keeps the expected pin levels
	class pin_predictor;
		logic [3:0]  seq_phase;
		logic [3:0]  slot_idx;
		logic [15:0] tx_bits;
		logic [7:0]  rx_byte;
		logic [7:0]  hold_cnt;
		logic        rd_mode;
		logic [7:0]  half_ticks;
		res_t        expected_pins[$];
		int unsigned errors;

		function new();
			seq_phase  = PH_IDLE;
			slot_idx   = '0;
			tx_bits    = '0;
			rx_byte    = '0;
			hold_cnt   = '0;
			rd_mode    = 1'b0;
			half_ticks = HALF_RESET;
			errors     = 0;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s expected %h actual %h", what, want, got);
		endfunction

		function void note_tick(tick_t t);
			res_t r;
			logic fin;
			logic slot;
			fin  = 1'b0;
			slot = 1'b0;
			if (seq_phase == PH_IDLE) begin
				// a start while busy never gets here, so it is dropped
				if (t.start_req) begin
					rd_mode   = !t.req_type;
					tx_bits   = t.req_type ? {t.write_data, t.command} : {8'h00, t.command};
					if (rd_mode)
						rx_byte = 8'h00;
					slot_idx  = '0;
					hold_cnt  = '0;
					seq_phase = PH_CE_LOW;
				end
			end else begin
				hold_cnt = hold_cnt + 8'd1;
				// a zero half period acts as one
				if (hold_cnt >= half_ticks) begin
					hold_cnt = '0;
					case (seq_phase)
						PH_CE_LOW:  seq_phase = PH_CLK_LOW;
						PH_CLK_LOW: seq_phase = PH_CE_HIGH;
						PH_CE_HIGH: seq_phase = PH_SETUP;
						PH_SETUP: begin
							if (rd_mode && slot_idx[3])
								rx_byte = {t.io_in, rx_byte[7:1]};
							seq_phase = PH_CLK_HI;
						end
						PH_CLK_HI:  seq_phase = PH_CLK_LO;
						PH_CLK_LO: begin
							tx_bits = tx_bits >> 1;
							if (slot_idx == LAST_BIT) begin
								seq_phase = PH_END_CLK;
							end else begin
								slot_idx  = slot_idx + 4'd1;
								seq_phase = PH_SETUP;
							end
						end
						PH_END_CLK: seq_phase = PH_END_CE;
						PH_END_CE: begin
							seq_phase = PH_IDLE;
							fin       = 1'b1;
						end
						default:    seq_phase = PH_IDLE;
					endcase
				end
			end

			r = '0;
			case (seq_phase)
				PH_CE_LOW:  r.serial_clock = 1'b1;
				PH_CLK_LOW: r = '0;
				PH_CE_HIGH: r.chip_enable = 1'b1;
				PH_SETUP: begin
					r.chip_enable = 1'b1;
					slot          = 1'b1;
				end
				PH_CLK_HI: begin
					r.chip_enable  = 1'b1;
					r.serial_clock = 1'b1;
					slot           = 1'b1;
				end
				PH_CLK_LO: begin
					r.chip_enable = 1'b1;
					slot          = 1'b1;
				end
				PH_END_CLK: begin
					r.chip_enable  = 1'b1;
					r.serial_clock = 1'b1;
				end
				default:    r.serial_clock = 1'b1;
			endcase
			// read bit slots leave the data line released
			if (slot && !(rd_mode && slot_idx[3])) begin
				r.io_drive = 1'b1;
				r.io_out   = tx_bits[0];
			end
			r.busy_res  = (seq_phase != PH_IDLE);
			r.done_res  = fin;
			r.read_data = rx_byte;
			expected_pins.push_back(r);
		endfunction

		function void check_pins(res_t got);
			res_t want;
			if (expected_pins.size() == 0) begin
				flag("unexpected result transfer", '0, got);
				return;
			end
			want = expected_pins.pop_front();
			if (got.chip_enable !== want.chip_enable || got.serial_clock !== want.serial_clock ||
			    got.io_out !== want.io_out || got.io_drive !== want.io_drive ||
			    got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
			    got.read_data !== want.read_data)
				flag("ce,sclk,io,drv,busy,done,rd", want, got);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	pin_predictor pins;
	int unsigned  cycles;
	int unsigned  tx_idle_pct;
	int unsigned  rx_stall_pct;
	int unsigned  hold_left;
	bit           hold_req;

	three_wire_serial_master i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls plus the long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_OFF;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pins.check_pins(res_t'(m_tdata[RES_W-1:0]));
	end

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
	                          output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_half_period(input logic [7:0] value);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_HALF_PERIOD, {24'h0, value}, rd);
		pins.half_ticks = value;
		apb_access(1'b0, ADDR_HALF_PERIOD, '0, rd);
		if (rd !== {24'h0, value})
			pins.flag("half_period readback", {24'h0, value}, rd);
	endtask

	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, t.io_in, t.write_data, t.command, t.start_req};
		s_tuser  <= t.req_type;
		do @(posedge clk); while (!s_tready);
		pins.note_tick(t);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_ticks(input int unsigned n);
		tick_t t;
		for (int unsigned i = 0; i < n; i++) begin
			t.start_req  = ($urandom_range(7) == 0);
			t.req_type   = 1'($urandom);
			t.command    = pick_byte();
			t.write_data = pick_byte();
			t.io_in      = 1'($urandom);
			send_tick(t);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pins.expected_pins.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] half, input int unsigned tx_pct,
	                         input int unsigned rx_pct, input int unsigned n, input bit squeeze);
		wait_drained();
		set_half_period(half);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		if (squeeze)
			hold_req = 1'b1;
		send_random_ticks(n);
	endtask

	initial begin
		tick_t       t;
		logic [31:0] rd;
		pins         = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		m_tready     = 1'b0;
		cycles       = 0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_left    = 0;
		hold_req     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_access(1'b0, ADDR_HALF_PERIOD, '0, rd);
		if (rd !== {24'h0, HALF_RESET})
			pins.flag("half_period after reset", {24'h0, HALF_RESET}, rd);

		// directed: write with extreme bytes, then starts while busy are dropped
		set_half_period(8'd1);
		t = '{start_req: 1'b1, req_type: 1'b1, command: 8'hFF, write_data: 8'h00, io_in: 1'b0};
		send_tick(t);
		t = '{start_req: 1'b1, req_type: 1'b0, command: 8'h00, write_data: 8'hFF, io_in: 1'b1};
		send_tick(t);
		for (int i = 0; i < 22; i++) begin
			t = '{start_req: i[0], req_type: i[1], command: i[2] ? 8'hFF : 8'h00,
			      write_data: i[2] ? 8'h00 : 8'hFF, io_in: i[0] ^ i[1]};
			send_tick(t);
		end
		s_tvalid <= 1'b0;

		run_phase(8'd1,   0,  0,  300, 1'b0);
		run_phase(8'd2,   64, 0,  300, 1'b0);
		run_phase(8'd1,   0,  64, 300, 1'b0);
		run_phase(8'd3,   34, 34, 300, 1'b0);
		run_phase(8'd0,   0,  0,  200, 1'b1);
		run_phase(8'd255, 0,  0,  150, 1'b0);
		run_phase(8'd4,   34, 34, 100, 1'b0);

		wait_drained();
		if (pins.expected_pins.size() != 0)
			pins.flag("results left over", '0, pins.expected_pins.size());
		if (pins.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
